// ===== hdl/askld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askld_pkg
// Shared widths, codes and control types for the ADC scan key ladder decoder.
// ----------------------------------------------------------------------------
package askld_pkg;

   localparam int SAMPLE_BITS     = 10;
   localparam int BOUND_BITS      = 10;
   localparam int RATIO_BITS      = 16;
   localparam int SCALE_BITS      = 7;
   localparam int PROD_BITS       = SAMPLE_BITS + SCALE_BITS;
   localparam int DIV_CNT_BITS    = $clog2(PROD_BITS);
   localparam int CH_BITS         = 3;
   localparam int KEY_IDX_BITS    = 3;
   localparam int MAX_WINDOWS     = 8;
   localparam int KEY_WINDOWS_DEF = 8;

   localparam int CSR_DATA_BITS   = 40;
   localparam int CSR_IDX_BITS    = 2;
   localparam int REQ_TDATA_BITS  = 16;
   localparam int RSP_TDATA_BITS  = 40;

   localparam logic [SCALE_BITS-1:0] RATIO_SCALE = 7'd100;
   localparam logic [RATIO_BITS-1:0] RATIO_MAX   = '1;

   // csr register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW_A  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW_B  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH_A = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH_B = 2'd3;

   // scan rotation phases
   localparam logic [1:0] PH_KEY  = 2'd0;
   localparam logic [1:0] PH_REF  = 2'd1;
   localparam logic [1:0] PH_BATT = 2'd2;
   localparam logic [1:0] PH_USB  = 2'd3;

   // channel numbers
   localparam logic [CH_BITS-1:0] CH_KEY  = 3'd3;
   localparam logic [CH_BITS-1:0] CH_REF  = 3'd7;
   localparam logic [CH_BITS-1:0] CH_BATT = 3'd0;
   localparam logic [CH_BITS-1:0] CH_USB  = 3'd2;

   // rsp_tdata field offsets
   localparam int OFS_SAMPLED = 0;
   localparam int OFS_NEXT    = OFS_SAMPLED + CH_BITS;
   localparam int OFS_RATIO   = OFS_NEXT + CH_BITS;
   localparam int OFS_RZERO   = OFS_RATIO + RATIO_BITS;
   localparam int OFS_USB     = OFS_RZERO + 1;
   localparam int OFS_FOUND   = OFS_USB + SAMPLE_BITS;
   localparam int OFS_KEYIDX  = OFS_FOUND + 1;
   localparam int RSP_USED    = OFS_KEYIDX + KEY_IDX_BITS;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic div_store;
      logic out_load;
   } askld_cmd_type;

   typedef struct packed {
      logic div_needed;
      logic out_free;
   } askld_status_type;

   function automatic logic [CH_BITS-1:0] phase_channel(input logic [1:0] phase);
      logic [CH_BITS-1:0] ch;
      unique case (phase)
         PH_KEY:  ch = CH_KEY;
         PH_REF:  ch = CH_REF;
         PH_BATT: ch = CH_BATT;
         PH_USB:  ch = CH_USB;
         default: ch = CH_KEY;
      endcase
      return ch;
   endfunction

endpackage

// ===== hdl/askld_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askld_ctrl
// Sequencer: request capture, divider iterations, ratio store, result load.
// ----------------------------------------------------------------------------
module askld_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  askld_pkg::askld_status_type status,
   output askld_pkg::askld_cmd_type    cmd
);
   import askld_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_SAVE   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                     accept;
   logic                     last_step;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign last_step  = (cnt_ff == DIV_CNT_BITS'(PROD_BITS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               state_in    = status.div_needed ? ST_DIVIDE : ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last_step) begin
               state_in = ST_SAVE;
            end
         end
         ST_SAVE: begin
            cmd.div_store = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hdl/askld_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askld_datapath
// Channel stores, restoring divider, key window match and result register.
// ----------------------------------------------------------------------------
module askld_datapath #(
   parameter int KEY_WINDOWS = askld_pkg::KEY_WINDOWS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [askld_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [askld_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   input  logic                                    csr_we,
   input  logic [askld_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [askld_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  askld_pkg::askld_cmd_type                cmd,
   output askld_pkg::askld_status_type             status
);
   import askld_pkg::*;

   logic [1:0]              phase_ff, cap_phase_ff;
   logic [SAMPLE_BITS-1:0]  key_ff, ref_ff, usb_ff;
   logic [RATIO_BITS-1:0]   ratio_ff;
   logic                    rzero_ff;
   logic [SAMPLE_BITS-1:0]  rem_ff, rem_in;
   logic [PROD_BITS-1:0]    quo_ff, quo_in;
   logic [BOUND_BITS-1:0]   low_ff  [KEY_WINDOWS];
   logic [BOUND_BITS-1:0]   high_ff [KEY_WINDOWS];
   logic                    rsp_valid_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff;

   logic [SAMPLE_BITS-1:0]  sample;
   logic [PROD_BITS-1:0]    product;
   logic [SAMPLE_BITS:0]    shifted;
   logic [SAMPLE_BITS+1:0]  diff;
   logic                    ge;
   logic [RATIO_BITS-1:0]   ratio_sat;
   logic                    found;
   logic [KEY_IDX_BITS-1:0] key_idx;
   logic [RSP_TDATA_BITS-1:0] rsp_pack;

   assign sample  = req_tdata[SAMPLE_BITS-1:0];
   assign product = PROD_BITS'(sample) * PROD_BITS'(RATIO_SCALE);

   assign status.div_needed = (phase_ff == PH_BATT) && (ref_ff != '0);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   // restoring division, one quotient bit per step
   assign shifted = {rem_ff, quo_ff[PROD_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, ref_ff};
   assign ge      = !diff[SAMPLE_BITS+1];
   assign rem_in  = ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
   assign quo_in  = {quo_ff[PROD_BITS-2:0], ge};

   assign ratio_sat = (|quo_ff[PROD_BITS-1:RATIO_BITS]) ? RATIO_MAX
                                                         : quo_ff[RATIO_BITS-1:0];

   always_comb begin
      found   = 1'b0;
      key_idx = '0;
      for (int k = KEY_WINDOWS - 1; k >= 0; k--) begin
         if (key_ff >= low_ff[k] && key_ff <= high_ff[k]) begin
            found   = 1'b1;
            key_idx = KEY_IDX_BITS'(k);
         end
      end
   end

   always_comb begin
      rsp_pack = '0;
      rsp_pack[OFS_SAMPLED +: CH_BITS]     = phase_channel(cap_phase_ff);
      rsp_pack[OFS_NEXT +: CH_BITS]        = phase_channel(phase_ff);
      rsp_pack[OFS_RATIO +: RATIO_BITS]    = ratio_ff;
      rsp_pack[OFS_RZERO]                  = rzero_ff;
      rsp_pack[OFS_USB +: SAMPLE_BITS]     = usb_ff;
      rsp_pack[OFS_FOUND]                  = found;
      rsp_pack[OFS_KEYIDX +: KEY_IDX_BITS] = key_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_KEY;
         key_ff   <= '0;
         ref_ff   <= '0;
         usb_ff   <= '0;
         ratio_ff <= '0;
         rzero_ff <= 1'b0;
      end else if (cmd.capture) begin
         phase_ff <= phase_ff + 2'd1;
         unique case (phase_ff)
            PH_KEY:  key_ff <= sample;
            PH_REF:  ref_ff <= sample;
            PH_BATT: begin
               if (ref_ff == '0) begin
                  ratio_ff <= RATIO_MAX;
                  rzero_ff <= 1'b1;
               end
            end
            PH_USB:  usb_ff <= sample;
            default: usb_ff <= usb_ff;
         endcase
      end else if (cmd.div_store) begin
         ratio_ff <= ratio_sat;
         rzero_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_phase_ff <= phase_ff;
         rem_ff       <= '0;
         quo_ff       <= product;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   for (genvar k = 0; k < KEY_WINDOWS; k++) begin : g_win
      localparam logic [CSR_IDX_BITS-1:0] LOW_IDX  = (k < 4) ? CSR_LOW_A : CSR_LOW_B;
      localparam logic [CSR_IDX_BITS-1:0] HIGH_IDX = (k < 4) ? CSR_HIGH_A : CSR_HIGH_B;
      localparam int LSB = (k % 4) * BOUND_BITS;

      always_ff @(posedge clock) begin
         if (reset) begin
            low_ff[k]  <= '0;
            high_ff[k] <= '0;
         end else if (csr_we) begin
            if (csr_index == LOW_IDX) begin
               low_ff[k] <= csr_wdata[LSB +: BOUND_BITS];
            end
            if (csr_index == HIGH_IDX) begin
               high_ff[k] <= csr_wdata[LSB +: BOUND_BITS];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_pack;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/adc_scan_key_ladder_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_scan_key_ladder_decoder
// ADC scan rotation (3, 7, 0, 2), battery ratio and resistor ladder key decode.
// ----------------------------------------------------------------------------
// Channel   Ports                   Content
// req       req_tvalid/tready/tdata adc_sample in tdata[9:0]
// rsp       rsp_tvalid/tready/tdata one result per request
// csr       csr_we/index/wdata      window bounds, indexes 0..3
//
// A battery request with a nonzero reference runs through the 17-step restoring
// divider (one quotient bit a cycle); other requests skip the divider.
// Reset is synchronous and needs no clearing pass.
// The result register holds while rsp_tready is low; the next request is
// accepted and processed meanwhile, then waits for the result register.
// ----------------------------------------------------------------------------
module adc_scan_key_ladder_decoder #(
   parameter int KEY_WINDOWS = askld_pkg::KEY_WINDOWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [9:0] adc_sample, [15:10] zero
   input  logic [askld_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] sampled_channel, [5:3] next_channel, [21:6] battery_ratio,
   // [22] reference_zero, [32:23] usb_level, [33] key_found,
   // [36:34] key_index, [39:37] zero
   output logic [askld_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                                 csr_we,
   input  logic [askld_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [askld_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import askld_pkg::*;

   askld_cmd_type    cmd;
   askld_status_type status;

   askld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   askld_datapath #(
      .KEY_WINDOWS (KEY_WINDOWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== hdl/askld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// askld_checker
// Port-level checks for the ADC scan key ladder decoder.
// ----------------------------------------------------------------------------
module askld_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [askld_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);
   import askld_pkg::*;

   logic [CH_BITS-1:0] s_ch, n_ch;

   assign s_ch = rsp_tdata[OFS_SAMPLED +: CH_BITS];
   assign n_ch = rsp_tdata[OFS_NEXT +: CH_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   a_rotation: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (s_ch == CH_KEY && n_ch == CH_REF) || (s_ch == CH_REF && n_ch == CH_BATT)
                  || (s_ch == CH_BATT && n_ch == CH_USB) || (s_ch == CH_USB && n_ch == CH_KEY))
      else $error("channel rotation broken");

   a_no_key_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[OFS_FOUND] |-> rsp_tdata[OFS_KEYIDX +: KEY_IDX_BITS] == '0)
      else $error("key index without match");

   a_zero_ref_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[OFS_RZERO] |-> rsp_tdata[OFS_RATIO +: RATIO_BITS] == RATIO_MAX)
      else $error("zero reference ratio not saturated");

endmodule

bind adc_scan_key_ladder_decoder askld_checker u_askld_checker (.*);

// ===== sim/adc_scan_key_ladder_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_scan_key_ladder_decoder_tb
// Self-checking bench for the ADC scan rotation and key ladder decoder.
// A directed table (after reset, zero reference, saturation, sample extremes)
// is followed by random conversions under six window settings and three
// request/response idling patterns. Every response is checked field by field against
// its typed row or an in-bench model of the rotation, battery ratio and window match.
// ----------------------------------------------------------------------------
module adc_scan_key_ladder_decoder_tb;
   import askld_pkg::*;

   typedef struct packed {
      logic [CH_BITS-1:0]      sampled_ch;
      logic [CH_BITS-1:0]      next_ch;
      logic [RATIO_BITS-1:0]   ratio;
      logic                    ref_zero;
      logic [SAMPLE_BITS-1:0]  usb;
      logic                    key_hit;
      logic [KEY_IDX_BITS-1:0] key_idx;
   } scan_result_t;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   typed;
      scan_result_t           res;
   } dir_row_t;

   localparam int SEG_ITEMS = 125;
   localparam int NUM_SEGS  = 6;
   localparam logic [CH_BITS-1:0] ROTATION [4] = '{CH_KEY, CH_REF, CH_BATT, CH_USB};

   // typed rows assume all window bounds at reset (every window is 0..0)
   localparam dir_row_t DIR_ROWS [20] = '{
      '{10'd0,    1'b1, '{CH_KEY,  CH_REF,  16'd0,     1'b0, 10'd0,    1'b1, 3'd0}},
      '{10'd0,    1'b1, '{CH_REF,  CH_BATT, 16'd0,     1'b0, 10'd0,    1'b1, 3'd0}},
      '{10'd1023, 1'b1, '{CH_BATT, CH_USB,  16'hFFFF,  1'b1, 10'd0,    1'b1, 3'd0}},
      '{10'd1023, 1'b1, '{CH_USB,  CH_KEY,  16'hFFFF,  1'b1, 10'd1023, 1'b1, 3'd0}},
      '{10'd1023, 1'b1, '{CH_KEY,  CH_REF,  16'hFFFF,  1'b1, 10'd1023, 1'b0, 3'd0}},
      '{10'd1,    1'b1, '{CH_REF,  CH_BATT, 16'hFFFF,  1'b1, 10'd1023, 1'b0, 3'd0}},
      '{10'd1023, 1'b1, '{CH_BATT, CH_USB,  16'hFFFF,  1'b0, 10'd1023, 1'b0, 3'd0}},
      '{10'd0,    1'b1, '{CH_USB,  CH_KEY,  16'hFFFF,  1'b0, 10'd0,    1'b0, 3'd0}},
      '{10'd0,    1'b1, '{CH_KEY,  CH_REF,  16'hFFFF,  1'b0, 10'd0,    1'b1, 3'd0}},
      '{10'd1023, 1'b0, '0},
      '{10'd1023, 1'b0, '0},
      '{10'd682,  1'b0, '0},
      '{10'd341,  1'b0, '0},
      '{10'd655,  1'b0, '0},
      '{10'd0,    1'b0, '0},
      '{10'd1,    1'b0, '0},
      '{10'd2,    1'b0, '0},
      '{10'd3,    1'b0, '0},
      '{10'd1023, 1'b0, '0},
      '{10'd512,  1'b0, '0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // model state
   logic [CSR_DATA_BITS-1:0]  bound_regs [4] = '{default: '0};
   logic [1:0]                scan_phase = PH_KEY;
   logic [SAMPLE_BITS-1:0]    key_level = '0;
   logic [SAMPLE_BITS-1:0]    ref_level = '0;
   logic [SAMPLE_BITS-1:0]    usb_level = '0;
   logic [RATIO_BITS-1:0]     batt_ratio = '0;
   logic                      batt_ref_zero = 1'b0;

   scan_result_t              pending_scans [$];
   int                        mismatch_count = 0;
   int                        send_idle_pct = 0;
   int                        rsp_idle_pct = 0;

   adc_scan_key_ladder_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [BOUND_BITS-1:0] window_bound(bit upper, int k);
      logic [CSR_DATA_BITS-1:0] r;
      if (upper) begin
         r = (k < 4) ? bound_regs[CSR_HIGH_A] : bound_regs[CSR_HIGH_B];
      end else begin
         r = (k < 4) ? bound_regs[CSR_LOW_A] : bound_regs[CSR_LOW_B];
      end
      return r[(k % 4) * BOUND_BITS +: BOUND_BITS];
   endfunction

   function automatic scan_result_t predict_scan(logic [SAMPLE_BITS-1:0] s);
      scan_result_t r;
      logic [1:0]   ph;
      int unsigned  q;
      ph = scan_phase;
      case (ph)
         PH_KEY: key_level = s;
         PH_REF: ref_level = s;
         PH_BATT: begin
            if (ref_level == 0) begin
               batt_ratio    = RATIO_MAX;
               batt_ref_zero = 1'b1;
            end else begin
               q = (int'(s) * 100) / int'(ref_level);
               batt_ratio    = (q > 65535) ? RATIO_MAX : RATIO_BITS'(q);
               batt_ref_zero = 1'b0;
            end
         end
         default: usb_level = s;
      endcase
      scan_phase   = ph + 2'd1;
      r.sampled_ch = ROTATION[ph];
      r.next_ch    = ROTATION[scan_phase];
      r.ratio      = batt_ratio;
      r.ref_zero   = batt_ref_zero;
      r.usb        = usb_level;
      r.key_hit    = 1'b0;
      r.key_idx    = '0;
      for (int k = 0; k < MAX_WINDOWS; k++) begin
         if (!r.key_hit && key_level >= window_bound(1'b0, k) &&
             key_level <= window_bound(1'b1, k)) begin
            r.key_hit = 1'b1;
            r.key_idx = KEY_IDX_BITS'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int v;
      int k;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 1023;
         2: v = $urandom_range(1, 3);
         3, 4, 5: v = $urandom_range(0, 1023);
         default: begin
            k = $urandom_range(0, 7);
            v = int'(window_bound(1'($urandom_range(0, 1)), k)) + $urandom_range(0, 2) - 1;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
         end
      endcase
      return SAMPLE_BITS'(v);
   endfunction

   // called at a falling edge; the caller drops csr_we after the last write
   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      bound_regs[idx] = data;
      @(negedge clock);
   endtask

   task automatic apply_windows(int setting);
      logic [BOUND_BITS-1:0]    lo [8];
      logic [BOUND_BITS-1:0]    hi [8];
      logic [CSR_DATA_BITS-1:0] lo_a, lo_b, hi_a, hi_b;
      int                       t;
      for (int k = 0; k < 8; k++) begin
         case (setting)
            0: begin
               lo[k] = BOUND_BITS'($urandom_range(0, 1023));
               hi[k] = BOUND_BITS'($urandom_range(0, 1023));
            end
            1: begin
               // contiguous ladder with gaps
               lo[k] = BOUND_BITS'(k * 128);
               hi[k] = BOUND_BITS'(k * 128 + $urandom_range(20, 127));
            end
            2: begin
               lo[k] = '0;
               hi[k] = '1;
            end
            3: begin
               lo[k] = '1;
               hi[k] = '0;
            end
            4: begin
               // overlapping windows, first one wins
               lo[k] = BOUND_BITS'($urandom_range(0, 1023));
               t     = int'(lo[k]) + $urandom_range(0, 300);
               hi[k] = (t > 1023) ? 10'd1023 : BOUND_BITS'(t);
            end
            default: begin
               lo[k] = ($urandom_range(0, 2) == 0) ? 10'd1023
                                                   : BOUND_BITS'($urandom_range(0, 900));
               hi[k] = ($urandom_range(0, 3) == 0) ? 10'd0
                                                   : BOUND_BITS'(lo[k] + $urandom_range(0, 60));
               if (k == 7) hi[k] = 10'd1023;
            end
         endcase
      end
      for (int k = 0; k < 4; k++) begin
         lo_a[k * BOUND_BITS +: BOUND_BITS] = lo[k];
         lo_b[k * BOUND_BITS +: BOUND_BITS] = lo[k + 4];
         hi_a[k * BOUND_BITS +: BOUND_BITS] = hi[k];
         hi_b[k * BOUND_BITS +: BOUND_BITS] = hi[k + 4];
      end
      csr_write(CSR_LOW_A, lo_a);
      csr_write(CSR_LOW_B, lo_b);
      csr_write(CSR_HIGH_A, hi_a);
      csr_write(CSR_HIGH_B, hi_b);
      csr_we <= 1'b0;
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_request(logic [SAMPLE_BITS-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'(s);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (pending_scans.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      scan_result_t got;
      scan_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sampled_ch = rsp_tdata[OFS_SAMPLED +: CH_BITS];
         got.next_ch    = rsp_tdata[OFS_NEXT +: CH_BITS];
         got.ratio      = rsp_tdata[OFS_RATIO +: RATIO_BITS];
         got.ref_zero   = rsp_tdata[OFS_RZERO];
         got.usb        = rsp_tdata[OFS_USB +: SAMPLE_BITS];
         got.key_hit    = rsp_tdata[OFS_FOUND];
         got.key_idx    = rsp_tdata[OFS_KEYIDX +: KEY_IDX_BITS];
         if (pending_scans.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response tdata=%h", rsp_tdata);
         end else begin
            want = pending_scans.pop_front();
            if (got.sampled_ch !== want.sampled_ch || got.next_ch !== want.next_ch ||
                got.ratio !== want.ratio || got.ref_zero !== want.ref_zero ||
                got.usb !== want.usb || got.key_hit !== want.key_hit ||
                got.key_idx !== want.key_idx) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch exp ch=%0d nxt=%0d ratio=%0d rz=%0d usb=%0d hit=%0d idx=%0d",
                           want.sampled_ch, want.next_ch, want.ratio, want.ref_zero,
                           want.usb, want.key_hit, want.key_idx);
                  $display("         got ch=%0d nxt=%0d ratio=%0d rz=%0d usb=%0d hit=%0d idx=%0d",
                           got.sampled_ch, got.next_ch, got.ratio, got.ref_zero,
                           got.usb, got.key_hit, got.key_idx);
               end
            end
         end
      end
   end

   initial begin : stimulus
      scan_result_t           want;
      logic [SAMPLE_BITS-1:0] s;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 22;
      rsp_idle_pct  = 61;
      foreach (DIR_ROWS[i]) begin
         want = predict_scan(DIR_ROWS[i].sample);
         pending_scans.push_back(DIR_ROWS[i].typed ? DIR_ROWS[i].res : want);
         send_request(DIR_ROWS[i].sample);
      end

      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         drain_requests();
         apply_windows(seg);
         send_idle_pct = (seg < 2) ? 22 : (seg < 4) ? 61 : 0;
         rsp_idle_pct  = (seg < 2) ? 61 : (seg < 4) ? 22 : 0;
         repeat (SEG_ITEMS) begin
            s = pick_sample();
            pending_scans.push_back(predict_scan(s));
            send_request(s);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && pending_scans.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/askld_pkg.sv
hdl/askld_ctrl.sv
hdl/askld_datapath.sv
hdl/adc_scan_key_ladder_decoder.sv
hdl/askld_checker.sv
sim/adc_scan_key_ladder_decoder_tb.sv
